// ===== hdl/shsc_pkg.sv =====
// ----------------------------------------------------------------------------
// shsc_pkg
// Types, register indexes, reset values and helpers shared by the string hash
// slot checker.
// ----------------------------------------------------------------------------
package shsc_pkg;

    localparam int TABLE_SIZE_W   = 11;
    localparam int MULT_W         = 11;
    localparam int MASK_W         = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CHAR_W         = 8;
    localparam int ENTRY_W        = 8;
    localparam int COLL_W         = 16;
    localparam int SLOT_INDEX_W   = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MULTIPLIER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_MASK  = 2'd2;

    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;
    localparam logic [MULT_W-1:0]       MULT_RST       = 11'd2;
    localparam logic [MASK_W-1:0]       MASK_RST       = 16'h0fff;

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [COLL_W-1:0] COLL_MAX = 16'hffff;

    typedef struct packed {
        logic              opcode;
        logic [CHAR_W-1:0] char_byte;
        logic [7:0]        key_length;
        logic              first_char;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic [ENTRY_W-1:0]      entry_number;
        logic                    collided;
        logic [COLL_W-1:0]       collision_total;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic clear;
    } hash_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_UPDATE
    } state_t;

    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

// ===== hdl/shsc_slot_ram.sv =====
// ----------------------------------------------------------------------------
// shsc_slot_ram
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module shsc_slot_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [shsc_pkg::ENTRY_W-1:0] wdata,
    input  logic                         re,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [shsc_pkg::ENTRY_W-1:0] rdata
);

    logic [shsc_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [shsc_pkg::ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/shsc_hash_unit.sv =====
// ----------------------------------------------------------------------------
// shsc_hash_unit
// Running hash: case fold, multiply-add and mask, one character per cycle while ctrl.load is set.
// ----------------------------------------------------------------------------
module shsc_hash_unit #(
    parameter int HASH_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  shsc_pkg::hash_ctrl_t              ctrl,
    input  shsc_pkg::in_item_t                item,
    input  logic [shsc_pkg::MULT_W-1:0]       multiplier,
    input  logic [shsc_pkg::MASK_W-1:0]       hash_mask,
    output logic [HASH_WIDTH-1:0]             hash
);

    localparam int SUM_W = HASH_WIDTH + shsc_pkg::MULT_W + 1;

    logic [HASH_WIDTH-1:0] hash_reg;
    logic [HASH_WIDTH-1:0] hash_next;
    logic [HASH_WIDTH-1:0] seed;
    logic [SUM_W-1:0]      sum;
    logic                  empty_key;

    assign empty_key = item.first_char && (item.key_length == 8'd0);
    assign seed      = item.first_char ? HASH_WIDTH'(item.key_length) : hash_reg;
    assign sum       = SUM_W'(seed) * SUM_W'(multiplier)
                     + SUM_W'(shsc_pkg::fold_upper(item.char_byte));

    always_comb begin
        hash_next = hash_reg;
        if (ctrl.clear) begin
            hash_next = '0;
        end else if (ctrl.load) begin
            if (empty_key) begin
                hash_next = '0;
            end else begin
                hash_next = sum[HASH_WIDTH-1:0] & HASH_WIDTH'(hash_mask);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
        end else begin
            hash_reg <= hash_next;
        end
    end

    assign hash = hash_reg;

endmodule

// ===== hdl/shsc_mod_unit.sv =====
// ----------------------------------------------------------------------------
// shsc_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module shsc_mod_unit #(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_W-1:0]      cnt_reg,   cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg,   dvd_next;
    logic [DIVISOR_W-1:0]  dsr_reg,   dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_W:0]    trial;

    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/string_hash_slot_checker.sv =====
// ----------------------------------------------------------------------------
// string_hash_slot_checker
// Hashes keys a character at a time and checks each finished key against a
// slot table held in a single-port-write, registered-read memory.
//
// A character that does not end a key leaves the block ready for the next one. A
// key that ends passes from acceptance through loading the remainder unit, the
// bit-serial remainder unit, a memory read and a read-modify-write until its
// result is loaded into the output register. The next transaction is taken once
// the result is registered, so a result may wait on m_ready while the next
// characters are hashed. After reset and after every clear transaction the table
// is swept to empty with s_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module string_hash_slot_checker #(
    parameter int TABLE_DEPTH = 1024,
    parameter int HASH_WIDTH  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [shsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [shsc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  shsc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output shsc_pkg::out_item_t                 m_data
);

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (SIZE_W > shsc_pkg::TABLE_SIZE_W) ? SIZE_W
                                                               : shsc_pkg::TABLE_SIZE_W;

    shsc_pkg::state_t state_reg, state_next;

    logic [shsc_pkg::TABLE_SIZE_W-1:0] table_size_reg;
    logic [shsc_pkg::MULT_W-1:0]       mult_reg;
    logic [shsc_pkg::MASK_W-1:0]       mask_reg;

    logic [SLOT_W-1:0]            clr_addr_reg;
    logic [shsc_pkg::ENTRY_W-1:0] entry_reg;
    logic [shsc_pkg::COLL_W-1:0]  coll_reg;
    logic                         m_valid_reg;
    shsc_pkg::out_item_t          m_data_reg;

    shsc_pkg::hash_ctrl_t         hash_ctrl;
    logic [HASH_WIDTH-1:0]        hash;
    logic                         accept;
    logic                         key_end;
    logic                         clr_last;
    logic                         out_free;
    logic                         update_fire;
    logic                         slot_empty;
    logic [CMP_W-1:0]             size_wide;
    logic [SIZE_W-1:0]            eff_size;
    logic                         div_start;
    logic                         div_done;
    logic [SIZE_W-1:0]            rem;
    logic [SLOT_W-1:0]            slot;
    logic                         mem_we;
    logic [SLOT_W-1:0]            mem_waddr;
    logic [shsc_pkg::ENTRY_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [shsc_pkg::ENTRY_W-1:0] mem_rdata;
    logic [shsc_pkg::ENTRY_W-1:0] entry_inc;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= shsc_pkg::TABLE_SIZE_RST;
            mult_reg       <= shsc_pkg::MULT_RST;
            mask_reg       <= shsc_pkg::MASK_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                shsc_pkg::CFG_TABLE_SIZE: begin
                    table_size_reg <= cfg_wdata[shsc_pkg::TABLE_SIZE_W-1:0];
                end
                shsc_pkg::CFG_MULTIPLIER: begin
                    mult_reg <= cfg_wdata[shsc_pkg::MULT_W-1:0];
                end
                shsc_pkg::CFG_HASH_MASK: begin
                    mask_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // effective size: zero acts as one, clamp to the table depth
    assign size_wide = CMP_W'(table_size_reg);
    always_comb begin
        if (table_size_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (size_wide > CMP_W'(TABLE_DEPTH)) begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            eff_size = SIZE_W'(size_wide);
        end
    end

    assign accept    = s_valid && s_ready;
    assign key_end   = s_data.last_char
                    || (s_data.first_char && (s_data.key_length == 8'd0));
    assign clr_last  = (clr_addr_reg == SLOT_W'(TABLE_DEPTH - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign slot      = SLOT_W'(rem);
    assign slot_empty = (mem_rdata == '0);
    assign entry_inc = entry_reg + shsc_pkg::ENTRY_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            shsc_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = shsc_pkg::ST_IDLE;
                end
            end
            shsc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == shsc_pkg::OP_CLEAR) begin
                        state_next = shsc_pkg::ST_CLEAR;
                    end else if (key_end) begin
                        state_next = shsc_pkg::ST_START;
                    end
                end
            end
            shsc_pkg::ST_START: begin
                state_next = shsc_pkg::ST_DIV;
            end
            shsc_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = shsc_pkg::ST_UPDATE;
                end
            end
            shsc_pkg::ST_UPDATE: begin
                if (out_free) begin
                    state_next = shsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = shsc_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_ready         = 1'b0;
        hash_ctrl.load  = 1'b0;
        hash_ctrl.clear = 1'b0;
        div_start       = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = slot;
        mem_wdata       = entry_inc;
        update_fire     = 1'b0;
        unique case (state_reg)
            shsc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            shsc_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                hash_ctrl.load  = s_valid && (s_data.opcode == shsc_pkg::OP_CHAR);
                hash_ctrl.clear = s_valid && (s_data.opcode == shsc_pkg::OP_CLEAR);
            end
            shsc_pkg::ST_START: begin
                div_start = 1'b1;
            end
            shsc_pkg::ST_DIV: begin
                mem_re = div_done;
            end
            shsc_pkg::ST_UPDATE: begin
                update_fire = out_free;
                mem_we      = out_free && slot_empty;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= shsc_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (state_reg == shsc_pkg::ST_CLEAR) begin
            if (clr_last) begin
                clr_addr_reg <= '0;
            end else begin
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
            end
        end
    end

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            coll_reg  <= '0;
        end else if (hash_ctrl.clear) begin
            entry_reg <= '0;
            coll_reg  <= '0;
        end else if (update_fire) begin
            if (slot_empty) begin
                entry_reg <= entry_inc;
            end else if (coll_reg != shsc_pkg::COLL_MAX) begin
                coll_reg <= coll_reg + shsc_pkg::COLL_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (update_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (update_fire) begin
            m_data_reg.slot_index <= shsc_pkg::SLOT_INDEX_W'(slot);
            if (slot_empty) begin
                m_data_reg.entry_number    <= entry_inc;
                m_data_reg.collided        <= 1'b0;
                m_data_reg.collision_total <= coll_reg;
            end else begin
                m_data_reg.entry_number <= '0;
                m_data_reg.collided     <= 1'b1;
                if (coll_reg != shsc_pkg::COLL_MAX) begin
                    m_data_reg.collision_total <= coll_reg + shsc_pkg::COLL_W'(1);
                end else begin
                    m_data_reg.collision_total <= coll_reg;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    shsc_hash_unit #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_hash (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (hash_ctrl),
        .item       (s_data),
        .multiplier (mult_reg),
        .hash_mask  (mask_reg),
        .hash       (hash)
    );

    shsc_mod_unit #(
        .DIVIDEND_W (HASH_WIDTH),
        .DIVISOR_W  (SIZE_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (hash),
        .divisor   (eff_size),
        .done      (div_done),
        .remainder (rem)
    );

    shsc_slot_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (slot),
        .rdata (mem_rdata)
    );

endmodule

// ===== test/string_hash_slot_checker_test.sv =====
// ----------------------------------------------------------------------------
// string_hash_slot_checker_test
// Self-checking bench for the string hash slot checker. A directed table and
// random key streams are hashed by a local slot-table predictor, and every
// result transaction is compared in order against it or against the row's
// fixed result. Covers the register extremes, clears and entry-number wrap,
// under several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module string_hash_slot_checker_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;
    localparam int HASH_WIDTH  = 16;
    localparam logic OP_CHAR   = shsc_pkg::OP_CHAR;
    localparam logic OP_CLEAR  = shsc_pkg::OP_CLEAR;
    localparam shsc_pkg::out_item_t NO_REPORT = '0;

    typedef struct packed {
        shsc_pkg::in_item_t  stim;
        logic                typed;
        shsc_pkg::out_item_t want;
    } probe_row_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [shsc_pkg::CFG_INDEX_W-1:0] cfg_index = shsc_pkg::CFG_TABLE_SIZE;
    logic [shsc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    shsc_pkg::in_item_t               s_data    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    shsc_pkg::out_item_t              m_data;

    // predictor state
    logic [15:0]        hash_acc;
    logic [7:0]         slot_owner [TABLE_DEPTH];
    logic [7:0]         entry_count;
    logic [15:0]        collision_count;
    logic [10:0]        size_reg;
    logic [10:0]        mult_reg;
    logic [15:0]        mask_reg;

    shsc_pkg::out_item_t slot_reports_due [$];
    shsc_pkg::out_item_t oldest_report;
    int                  mismatches     = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    probe_row_t          probe_rows [19];

    string_hash_slot_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .HASH_WIDTH (HASH_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic shsc_pkg::in_item_t pack_item(input logic op, input logic [7:0] ch,
                                                     input logic [7:0] klen,
                                                     input logic first, input logic last);
        shsc_pkg::in_item_t it;
        it.opcode     = op;
        it.char_byte  = ch;
        it.key_length = klen;
        it.first_char = first;
        it.last_char  = last;
        return it;
    endfunction

    function automatic probe_row_t row(input shsc_pkg::in_item_t stim, input logic typed,
                                       input logic [9:0] slot, input logic [7:0] entry,
                                       input logic coll, input logic [15:0] total);
        probe_row_t r;
        r.stim                 = stim;
        r.typed                = typed;
        r.want.slot_index      = slot;
        r.want.entry_number    = entry;
        r.want.collided        = coll;
        r.want.collision_total = total;
        return r;
    endfunction

    function automatic logic [7:0] upper_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(1) == 1) begin
            return 8'($urandom_range(25)) + (($urandom_range(1) == 1) ? 8'h61 : 8'h41);
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic empty_table();
        foreach (slot_owner[i]) begin
            slot_owner[i] = 8'd0;
        end
        hash_acc        = '0;
        entry_count     = '0;
        collision_count = '0;
    endtask

    // hash one character or clear the table; on the end of a key, probe and update the slot table
    task automatic hash_and_probe(input shsc_pkg::in_item_t it, output logic produced,
                                  output shsc_pkg::out_item_t res);
        logic [31:0] acc;
        logic [10:0] eff;
        logic [9:0]  slot;
        logic        ends;
        produced = 1'b0;
        res      = '0;
        if (it.opcode == OP_CLEAR) begin
            empty_table();
            return;
        end
        ends = it.last_char;
        if (it.first_char && it.key_length == 8'd0) begin
            hash_acc = '0;
            ends     = 1'b1;
        end else begin
            acc      = it.first_char ? 32'(it.key_length) : 32'(hash_acc);
            acc      = acc * 32'(mult_reg) + 32'(upper_case(it.char_byte));
            hash_acc = acc[15:0] & mask_reg;
        end
        if (!ends) begin
            return;
        end
        if (size_reg == 11'd0) begin
            eff = 11'd1;
        end else if (size_reg > 11'(TABLE_DEPTH)) begin
            eff = 11'(TABLE_DEPTH);
        end else begin
            eff = size_reg;
        end
        slot = 10'(32'(hash_acc) % 32'(eff));
        if (slot_owner[slot] == 8'd0) begin
            entry_count      = entry_count + 8'd1;
            slot_owner[slot] = entry_count;
            res.entry_number = entry_count;
            res.collided     = 1'b0;
        end else begin
            if (collision_count != shsc_pkg::COLL_MAX) begin
                collision_count = collision_count + 16'd1;
            end
            res.entry_number = 8'd0;
            res.collided     = 1'b1;
        end
        res.slot_index      = slot;
        res.collision_total = collision_count;
        produced            = 1'b1;
    endtask

    task automatic put_item(input shsc_pkg::in_item_t it, input logic typed,
                            input shsc_pkg::out_item_t fixed);
        logic                produced;
        shsc_pkg::out_item_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        hash_and_probe(it, produced, res);
        if (produced) begin
            slot_reports_due.push_back(typed ? fixed : res);
        end
    endtask

    // also lets a table sweep finish before the registers change
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (slot_reports_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TABLE_DEPTH + HASH_WIDTH + 8) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [10:0] size, input logic [10:0] mult,
                                 input logic [15:0] mask);
        cfg_we    <= 1'b1;
        cfg_index <= shsc_pkg::CFG_TABLE_SIZE;
        cfg_wdata <= 16'(size);
        @(posedge aclk);
        cfg_index <= shsc_pkg::CFG_MULTIPLIER;
        cfg_wdata <= 16'(mult);
        @(posedge aclk);
        cfg_index <= shsc_pkg::CFG_HASH_MASK;
        cfg_wdata <= mask;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        size_reg  = size;
        mult_reg  = mult;
        mask_reg  = mask;
    endtask

    // one clear, one stray character, or one whole key
    task automatic send_random_burst(inout int sent);
        int         pick;
        int         n;
        logic [7:0] klen;
        pick = $urandom_range(99);
        if (pick < 3) begin
            put_item(pack_item(OP_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               1'($urandom_range(1)), 1'($urandom_range(1))), 1'b0, NO_REPORT);
            sent++;
        end else if (pick < 12) begin
            put_item(pack_item(OP_CHAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               1'($urandom_range(1)), 1'($urandom_range(1))), 1'b0, NO_REPORT);
            sent++;
        end else begin
            n    = ($urandom_range(15) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 4);
            klen = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'(n);
            if (n == 0) begin
                put_item(pack_item(OP_CHAR, rand_char(), 8'd0, 1'b1, 1'($urandom_range(1))),
                         1'b0, NO_REPORT);
                sent++;
            end else begin
                for (int k = 0; k < n; k++) begin
                    put_item(pack_item(OP_CHAR, rand_char(),
                                       (k == 0) ? klen : 8'($urandom_range(255)),
                                       k == 0, k == n - 1), 1'b0, NO_REPORT);
                end
                sent += n;
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (slot_reports_due.size() == 0) begin
                $display("%0t: unexpected transaction: slot=%0d entry=%0d collided=%0b total=%0d",
                         $time, m_data.slot_index, m_data.entry_number, m_data.collided,
                         m_data.collision_total);
                mismatches++;
            end else begin
                oldest_report = slot_reports_due.pop_front();
                if (m_data !== oldest_report) begin
                    $display("%0t: mismatch: expected slot=%0d entry=%0d collided=%0b total=%0d",
                             $time, oldest_report.slot_index, oldest_report.entry_number,
                             oldest_report.collided, oldest_report.collision_total);
                    $display("%0t:           actual slot=%0d entry=%0d collided=%0b total=%0d",
                             $time, m_data.slot_index, m_data.entry_number, m_data.collided,
                             m_data.collision_total);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #60_000_000;
        $display("string_hash_slot_checker_test NOT OK");
        $finish;
    end

    initial begin
        int burst_items;

        probe_rows = '{
            row(pack_item(OP_CHAR,  8'hff, 8'd0,   1'b1, 1'b0), 1'b1, 10'd0, 8'd1, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h00, 8'd0,   1'b1, 1'b1), 1'b1, 10'd0, 8'd0, 1'b1, 16'd1),
            row(pack_item(OP_CHAR,  8'h61, 8'd1,   1'b1, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h41, 8'd1,   1'b1, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h7a, 8'd3,   1'b1, 1'b0), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h7b, 8'd3,   1'b0, 1'b0), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h60, 8'd3,   1'b0, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h40, 8'd9,   1'b0, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'hff, 8'hff,  1'b1, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h00, 8'hff,  1'b1, 1'b0), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h80, 8'h00,  1'b0, 1'b0), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h7a, 8'h55,  1'b0, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h55, 8'h80,  1'b1, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'haa, 8'h7f,  1'b1, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CLEAR, 8'hff, 8'hff,  1'b1, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h5a, 8'd0,   1'b1, 1'b1), 1'b1, 10'd0, 8'd1, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h33, 8'd0,   1'b1, 1'b0), 1'b1, 10'd0, 8'd0, 1'b1, 16'd1),
            row(pack_item(OP_CHAR,  8'h6d, 8'd0,   1'b0, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0),
            row(pack_item(OP_CHAR,  8'h01, 8'd1,   1'b1, 1'b1), 1'b0, 10'd0, 8'd0, 1'b0, 16'd0)
        };

        size_reg = shsc_pkg::TABLE_SIZE_RST;
        mult_reg = shsc_pkg::MULT_RST;
        mask_reg = shsc_pkg::MASK_RST;
        empty_table();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset register values
        foreach (probe_rows[i]) begin
            put_item(probe_rows[i].stim, probe_rows[i].typed, probe_rows[i].want);
        end
        wait_for_quiet();

        // zero size acts as one slot: every key after the first collides
        load_settings(11'd0, 11'd0, 16'h0000);
        put_item(pack_item(OP_CLEAR, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0, NO_REPORT);
        repeat (8) begin
            put_item(pack_item(OP_CHAR, rand_char(), 8'($urandom_range(255)), 1'b1, 1'b1),
                     1'b0, NO_REPORT);
        end
        wait_for_quiet();

        // distinct slots until the entry number wraps through zero
        load_settings(11'd1024, 11'd1, 16'hffff);
        put_item(pack_item(OP_CLEAR, 8'h5a, 8'ha5, 1'b1, 1'b0), 1'b0, NO_REPORT);
        for (int i = 0; i < 260; i++) begin
            put_item(pack_item(OP_CHAR, (i < 256) ? 8'h00 : 8'hc0, 8'(i), 1'b1, 1'b1),
                     1'b0, NO_REPORT);
        end
        wait_for_quiet();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    load_settings(11'd1024, 11'd2047, 16'hffff);
                end
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                    load_settings(11'($urandom_range(1, 1023)), 11'($urandom_range(2047)),
                                  16'($urandom_range(65535)));
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                    load_settings(11'd2047, 11'd1024, 16'h00ff);
                end
                default: begin
                    send_idle_pct  = 19;
                    recv_stall_pct = 19;
                    load_settings(11'($urandom_range(2, 64)), 11'($urandom_range(40)),
                                  16'h0fff);
                end
            endcase
            burst_items = 0;
            while (burst_items < 30) begin
                send_random_burst(burst_items);
            end
            wait_for_quiet();
        end

        if (mismatches == 0) begin
            $display("string_hash_slot_checker_test OK");
        end else begin
            $display("string_hash_slot_checker_test NOT OK");
        end
        $finish;
    end

endmodule
